// ----- design/m3i_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// m3i_pkg
// Types and constants shared by the 3x3 matrix inverse pipeline.
// ----------------------------------------------------------------------------
package m3i_pkg;

  typedef struct packed {
    logic signed [31:0] m00;
    logic signed [31:0] m01;
    logic signed [31:0] m02;
    logic signed [31:0] m10;
    logic signed [31:0] m11;
    logic signed [31:0] m12;
    logic signed [31:0] m20;
    logic signed [31:0] m21;
    logic signed [31:0] m22;
  } m3i_in_t;

  typedef struct packed {
    logic signed [31:0] r00;
    logic signed [31:0] r01;
    logic signed [31:0] r02;
    logic signed [31:0] r10;
    logic signed [31:0] r11;
    logic signed [31:0] r12;
    logic signed [31:0] r20;
    logic signed [31:0] r21;
    logic signed [31:0] r22;
    logic               singular;
    logic               saturated;
  } m3i_out_t;

  // Control carried alongside the divider lanes.
  typedef struct packed {
    logic       valid;
    logic       singular;
    logic [8:0] neg;
    logic [8:0] ovf;
  } m3i_ctl_t;

  localparam int unsigned DIV_STEPS = 32;
  localparam int unsigned FRONT_STAGES = 8;
  localparam logic [31:0] DET_MIN_RESET = 32'd42950;
  localparam logic [31:0] Q_POS_MAX = 32'h7FFF_FFFF;
  localparam logic [31:0] Q_NEG_MIN = 32'h8000_0000;

  // Cofactor i = e[A]*e[B] - e[C]*e[D], entries indexed row*3 + column.
  localparam int unsigned COF_A [9] = '{4, 2, 1, 5, 0, 3, 3, 6, 0};
  localparam int unsigned COF_B [9] = '{8, 7, 5, 6, 8, 2, 7, 1, 4};
  localparam int unsigned COF_C [9] = '{7, 1, 2, 3, 2, 0, 6, 0, 3};
  localparam int unsigned COF_D [9] = '{5, 8, 4, 8, 6, 5, 4, 7, 1};

endpackage
`default_nettype wire

// ----- design/m3i_divider.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// m3i_divider
// Pipelined restoring divider: (num * 2^32) / den for num < den, one
// quotient bit per stage.
// ----------------------------------------------------------------------------
module m3i_divider (
  input  wire logic        clk,
  input  wire logic        en,
  input  wire logic [63:0] num,
  input  wire logic [95:0] den,
  output logic      [31:0] quo
);

  localparam int unsigned STEPS = m3i_pkg::DIV_STEPS;

  logic [96:0] rem_r [STEPS-1];
  logic [95:0] den_r [STEPS-1];
  logic [31:0] q_r   [STEPS];

  for (genvar k = 0; k < STEPS; k++) begin : g_step
    logic [96:0] src;
    logic [95:0] dsrc;
    logic [31:0] qsrc;
    logic [96:0] sh;
    logic [97:0] diff;
    logic        ge;

    if (k == 0) begin : g_first
      assign src  = {33'b0, num};
      assign dsrc = den;
      assign qsrc = '0;
    end else begin : g_next
      assign src  = rem_r[k-1];
      assign dsrc = den_r[k-1];
      assign qsrc = q_r[k-1];
    end

    // The remainder stays below the divisor, so its top bit is always clear.
    always_comb begin
      sh   = {src[95:0], 1'b0};
      diff = {1'b0, sh} - {2'b0, dsrc};
      ge   = ~diff[97];
    end

    always_ff @(posedge clk) begin
      if (en) begin
        q_r[k] <= {qsrc[30:0], ge};
      end
    end

    if (k < STEPS - 1) begin : g_carry
      always_ff @(posedge clk) begin
        if (en) begin
          rem_r[k] <= ge ? diff[96:0] : sh;
          den_r[k] <= dsrc;
        end
      end
    end
  end

  assign quo = q_r[STEPS-1];

endmodule
`default_nettype wire

// ----- design/matrix3x3_inverse_top.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// matrix3x3_inverse_top
// Inverse of a signed Q16.16 3x3 matrix via adjugate over determinant, with
// singularity threshold and saturation to Q16.16.
// ----------------------------------------------------------------------------
//   channel | direction | handshake           | word
//   in      | input     | in_valid/in_ready   | m3i_in_t matrix
//   out     | output    | out_valid/out_ready | m3i_out_t inverse and flags
//   cfg     | input     | cfg_wr_en           | det_min threshold
//
// One word is accepted per cycle unless a result waits at the output. The
// path is 41 registers: eight front stages (products, cofactors,
// determinant), the 32 one-bit stages of the nine divider lanes and the
// output register, the first loading at the edge that accepts the word.
// Reset clears the valid bits and loads det_min with its default.
// While a result waits at the output the whole pipeline holds.
// ----------------------------------------------------------------------------
module matrix3x3_inverse_top (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire m3i_pkg::m3i_in_t  in_data,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output m3i_pkg::m3i_out_t      out_data,
  input  wire logic              cfg_wr_en,
  input  wire logic [31:0]       cfg_wr_data
);

  localparam int unsigned STEPS = m3i_pkg::DIV_STEPS;
  localparam int unsigned FRONT = m3i_pkg::FRONT_STAGES;

  logic        en;
  logic [31:0] det_min_r;
  logic        vf_r [FRONT];
  m3i_pkg::m3i_ctl_t ctl_r [STEPS];
  logic        out_valid_r;
  m3i_pkg::m3i_out_t out_data_r;

  logic signed [31:0] e [9];

  logic signed [63:0] pa_r [9];
  logic signed [63:0] pc_r [9];
  logic signed [31:0] e0_s1_r [3];
  logic signed [64:0] cof_r [9];
  logic signed [31:0] e0_s2_r [3];
  logic [63:0] cmag_s3_r [9];
  logic [8:0]  csgn_s3_r;
  logic [31:0] emag_r [3];
  logic [2:0]  esgn_r;
  logic [63:0] pl_r [3];
  logic [63:0] ph_r [3];
  logic [2:0]  tneg_r;
  logic [63:0] cmag_s4_r [9];
  logic [8:0]  csgn_s4_r;
  logic signed [97:0] t_r [3];
  logic [63:0] cmag_s5_r [9];
  logic [8:0]  csgn_s5_r;
  logic signed [97:0] det_r;
  logic [63:0] cmag_s6_r [9];
  logic [8:0]  csgn_s6_r;
  logic [95:0] dmag_r;
  logic        dneg_r;
  logic [63:0] cmag_s7_r [9];
  logic [8:0]  csgn_s7_r;
  logic [95:0] dmag_s8_r;
  logic [63:0] cmag_s8_r [9];
  logic        sing_s8_r;
  logic [8:0]  neg_s8_r;
  logic [8:0]  ovf_s8_r;

  logic [31:0] quo [9];
  logic [31:0] res [9];
  logic        sat_any;

  assign en       = ~out_valid_r | out_ready;
  assign in_ready = en;

  assign e[0] = in_data.m00;
  assign e[1] = in_data.m01;
  assign e[2] = in_data.m02;
  assign e[3] = in_data.m10;
  assign e[4] = in_data.m11;
  assign e[5] = in_data.m12;
  assign e[6] = in_data.m20;
  assign e[7] = in_data.m21;
  assign e[8] = in_data.m22;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      det_min_r <= m3i_pkg::DET_MIN_RESET;
    end else if (cfg_wr_en) begin
      det_min_r <= cfg_wr_data;
    end
  end

  // Valid bits for the front stages.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int s = 0; s < FRONT; s++) vf_r[s] <= 1'b0;
    end else if (en) begin
      vf_r[0] <= in_valid;
      for (int s = 1; s < FRONT; s++) vf_r[s] <= vf_r[s-1];
    end
  end

  // Front datapath: products, cofactors, magnitudes, determinant, compares.
  always_ff @(posedge clk) begin
    logic [64:0] ng;
    logic [95:0] pm;
    logic [97:0] dn;
    if (en) begin
      for (int i = 0; i < 9; i++) begin
        pa_r[i] <= 64'(e[m3i_pkg::COF_A[i]]) * 64'(e[m3i_pkg::COF_B[i]]);
        pc_r[i] <= 64'(e[m3i_pkg::COF_C[i]]) * 64'(e[m3i_pkg::COF_D[i]]);
      end
      for (int k = 0; k < 3; k++) e0_s1_r[k] <= e[k];

      for (int i = 0; i < 9; i++) begin
        cof_r[i] <= {pa_r[i][63], pa_r[i]} - {pc_r[i][63], pc_r[i]};
      end
      for (int k = 0; k < 3; k++) e0_s2_r[k] <= e0_s1_r[k];

      for (int i = 0; i < 9; i++) begin
        ng = -cof_r[i];
        cmag_s3_r[i] <= cof_r[i][64] ? ng[63:0] : cof_r[i][63:0];
        csgn_s3_r[i] <= cof_r[i][64];
      end
      for (int k = 0; k < 3; k++) begin
        emag_r[k] <= e0_s2_r[k][31] ? 32'(-e0_s2_r[k]) : e0_s2_r[k];
        esgn_r[k] <= e0_s2_r[k][31];
      end

      // Row-0 expansion uses cofactors 0, 3 and 6, split into 32-bit halves.
      for (int k = 0; k < 3; k++) begin
        pl_r[k]   <= 64'(emag_r[k]) * 64'(cmag_s3_r[k*3][31:0]);
        ph_r[k]   <= 64'(emag_r[k]) * 64'(cmag_s3_r[k*3][63:32]);
        tneg_r[k] <= esgn_r[k] ^ csgn_s3_r[k*3];
      end
      cmag_s4_r <= cmag_s3_r;
      csgn_s4_r <= csgn_s3_r;

      for (int k = 0; k < 3; k++) begin
        pm = {32'b0, pl_r[k]} + {ph_r[k], 32'b0};
        t_r[k] <= tneg_r[k] ? -$signed({2'b0, pm}) : $signed({2'b0, pm});
      end
      cmag_s5_r <= cmag_s4_r;
      csgn_s5_r <= csgn_s4_r;

      det_r     <= t_r[0] + t_r[1] + t_r[2];
      cmag_s6_r <= cmag_s5_r;
      csgn_s6_r <= csgn_s5_r;

      dn = -det_r;
      dmag_r    <= det_r[97] ? dn[95:0] : det_r[95:0];
      dneg_r    <= det_r[97];
      cmag_s7_r <= cmag_s6_r;
      csgn_s7_r <= csgn_s6_r;

      dmag_s8_r <= dmag_r;
      cmag_s8_r <= cmag_s7_r;
      sing_s8_r <= (dmag_r <= {48'b0, det_min_r, 16'b0});
      for (int i = 0; i < 9; i++) begin
        // A cofactor at least as large as |det| gives a quotient of 2^32 or more.
        ovf_s8_r[i] <= {32'b0, cmag_s7_r[i]} >= dmag_r;
        neg_s8_r[i] <= csgn_s7_r[i] ^ dneg_r;
      end
    end
  end

  // The last front valid bit belongs to the eighth stage.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int s = 0; s < STEPS; s++) ctl_r[s] <= '0;
    end else if (en) begin
      ctl_r[0] <= '{valid: vf_r[FRONT-1], singular: sing_s8_r, neg: neg_s8_r,
                    ovf: ovf_s8_r};
      for (int s = 1; s < STEPS; s++) ctl_r[s] <= ctl_r[s-1];
    end
  end

  for (genvar i = 0; i < 9; i++) begin : g_lane
    m3i_divider u_div (
      .clk (clk),
      .en  (en),
      .num (cmag_s8_r[i]),
      .den (dmag_s8_r),
      .quo (quo[i])
    );
  end

  always_comb begin
    sat_any = 1'b0;
    for (int i = 0; i < 9; i++) begin
      res[i] = '0;
      if (!ctl_r[STEPS-1].singular) begin
        if (ctl_r[STEPS-1].neg[i]) begin
          if (ctl_r[STEPS-1].ovf[i] || quo[i] > m3i_pkg::Q_NEG_MIN) begin
            res[i]  = m3i_pkg::Q_NEG_MIN;
            sat_any = 1'b1;
          end else begin
            res[i] = -quo[i];
          end
        end else begin
          if (ctl_r[STEPS-1].ovf[i] || quo[i] > m3i_pkg::Q_POS_MAX) begin
            res[i]  = m3i_pkg::Q_POS_MAX;
            sat_any = 1'b1;
          end else begin
            res[i] = quo[i];
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= ctl_r[STEPS-1].valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_data_r.r00       <= res[0];
      out_data_r.r01       <= res[1];
      out_data_r.r02       <= res[2];
      out_data_r.r10       <= res[3];
      out_data_r.r11       <= res[4];
      out_data_r.r12       <= res[5];
      out_data_r.r20       <= res[6];
      out_data_r.r21       <= res[7];
      out_data_r.r22       <= res[8];
      out_data_r.singular  <= ctl_r[STEPS-1].singular;
      out_data_r.saturated <= sat_any;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // A singular result is all zeros and never flagged as saturated.
  a_singular_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.singular |-> !out_data.saturated && out_data.r00 == 0
      && out_data.r11 == 0 && out_data.r22 == 0)
    else $error("singular result carries data or saturation");

  // Reset empties the output register.
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("output valid after reset");

  // The pipeline only advances when the output can move.
  a_hold_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |-> !in_ready)
    else $error("input taken while output stalled");

endmodule
`default_nettype wire

// ----- tb/matrix3x3_inverse_top_test.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// matrix3x3_inverse_top_test
// Drives Q16.16 3x3 matrices through the inverse pipeline and checks every
// result word against an exact adjugate-over-determinant prediction, with
// threshold changes between phases, random idling and back-pressure.
// ----------------------------------------------------------------------------
module matrix3x3_inverse_top_test;

  localparam int LATENCY = 41;
  localparam int WATCHDOG_LIMIT = 20000;

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_ready;
  m3i_pkg::m3i_in_t in_data;
  logic out_valid;
  logic out_ready;
  m3i_pkg::m3i_out_t out_data;
  logic cfg_wr_en;
  logic [31:0] cfg_wr_data;

  matrix3x3_inverse_top uut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data)
  );

  logic [31:0] threshold;
  m3i_pkg::m3i_out_t inverse_queue[$];
  int error_count;
  int idle_cycles;
  bit send_idling;
  bit recv_idling;
  int hold_off_cycles;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Exact inverse prediction; widths are generous enough for every product.
  function automatic m3i_pkg::m3i_out_t predict_inverse(m3i_pkg::m3i_in_t m,
                                                        logic [31:0] thr);
    logic signed [31:0] e [9];
    logic signed [69:0] cof [9];
    logic signed [107:0] det;
    logic [107:0] dmag, cmag;
    logic [139:0] quot;
    logic [31:0] r [9];
    logic neg;
    m3i_pkg::m3i_out_t res;
    e = '{m.m00, m.m01, m.m02, m.m10, m.m11, m.m12, m.m20, m.m21, m.m22};
    cof[0] = 70'(e[4]) * e[8] - 70'(e[7]) * e[5];
    cof[1] = 70'(e[2]) * e[7] - 70'(e[1]) * e[8];
    cof[2] = 70'(e[1]) * e[5] - 70'(e[2]) * e[4];
    cof[3] = 70'(e[5]) * e[6] - 70'(e[3]) * e[8];
    cof[4] = 70'(e[0]) * e[8] - 70'(e[2]) * e[6];
    cof[5] = 70'(e[3]) * e[2] - 70'(e[0]) * e[5];
    cof[6] = 70'(e[3]) * e[7] - 70'(e[6]) * e[4];
    cof[7] = 70'(e[6]) * e[1] - 70'(e[0]) * e[7];
    cof[8] = 70'(e[0]) * e[4] - 70'(e[3]) * e[1];
    det = 108'(e[0]) * cof[0] + 108'(e[1]) * cof[3] + 108'(e[2]) * cof[6];
    dmag = det[107] ? 108'(-det) : 108'(det);
    res = '0;
    if (dmag <= (108'(thr) << 16)) begin
      res.singular = 1'b1;
      return res;
    end
    for (int i = 0; i < 9; i++) begin
      cmag = cof[i][69] ? 108'(-108'(cof[i])) : 108'(108'(cof[i]));
      quot = (140'(cmag) << 32) / 140'(dmag);
      neg = cof[i][69] ^ det[107];
      if (neg) begin
        if (quot > 140'h8000_0000) begin
          r[i] = m3i_pkg::Q_NEG_MIN;
          res.saturated = 1'b1;
        end else begin
          r[i] = 32'(-quot);
        end
      end else if (quot > 140'h7FFF_FFFF) begin
        r[i] = m3i_pkg::Q_POS_MAX;
        res.saturated = 1'b1;
      end else begin
        r[i] = quot[31:0];
      end
    end
    {res.r00, res.r01, res.r02, res.r10, res.r11, res.r12, res.r20, res.r21, res.r22} =
      {r[0], r[1], r[2], r[3], r[4], r[5], r[6], r[7], r[8]};
    return res;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("mismatch %s: got %h, expected %h at %0t", what, got, want, $time);
    error_count++;
  endtask

  // Result checker and receiver stalls.
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (inverse_queue.size() == 0) begin
        report_mismatch("unexpected word", 32'h0, 32'h0);
      end else begin
        m3i_pkg::m3i_out_t w;
        w = inverse_queue.pop_front();
        if (out_data.r00 !== w.r00) report_mismatch("r00", out_data.r00, w.r00);
        if (out_data.r01 !== w.r01) report_mismatch("r01", out_data.r01, w.r01);
        if (out_data.r02 !== w.r02) report_mismatch("r02", out_data.r02, w.r02);
        if (out_data.r10 !== w.r10) report_mismatch("r10", out_data.r10, w.r10);
        if (out_data.r11 !== w.r11) report_mismatch("r11", out_data.r11, w.r11);
        if (out_data.r12 !== w.r12) report_mismatch("r12", out_data.r12, w.r12);
        if (out_data.r20 !== w.r20) report_mismatch("r20", out_data.r20, w.r20);
        if (out_data.r21 !== w.r21) report_mismatch("r21", out_data.r21, w.r21);
        if (out_data.r22 !== w.r22) report_mismatch("r22", out_data.r22, w.r22);
        if (out_data.singular !== w.singular)
          report_mismatch("singular", out_data.singular, w.singular);
        if (out_data.saturated !== w.saturated)
          report_mismatch("saturated", out_data.saturated, w.saturated);
      end
    end
  end

  initial begin
    int gap;
    out_ready = 1'b0;
    gap = 0;
    forever begin
      @(negedge clk);
      if (hold_off_cycles > 0) begin
        hold_off_cycles--;
        out_ready <= 1'b0;
      end else if (gap > 0) begin
        gap--;
        out_ready <= 1'b0;
      end else if (recv_idling && $urandom_range(0, 5) == 0) begin
        gap = $urandom_range(1, 6) - 1;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // Watchdog on cycles with no accepted word on either channel.
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  // Valid stays high after the word is taken, so words can follow back to back;
  // it drops only for idling or when the sender waits for the pipeline to empty.
  task automatic send_matrix(m3i_pkg::m3i_in_t m);
    if (send_idling && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data <= m;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    inverse_queue.push_back(predict_inverse(m, threshold));
    @(negedge clk);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (inverse_queue.size() != 0) @(negedge clk);
    repeat (LATENCY + 4) @(negedge clk);
  endtask

  task automatic write_threshold(logic [31:0] v);
    wait_drained();
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= v;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    threshold = v;
  endtask

  function automatic logic [31:0] rand_entry();
    case ($urandom_range(0, 5))
      0: return $urandom();
      1: return 32'($signed($urandom_range(0, 1 << 20)) - (1 << 19));
      2: return 32'($signed($urandom_range(0, 1 << 18)) - (1 << 17));
      3: return {{16{1'b0}}, 16'($urandom())} | ($urandom_range(0, 1) ? 32'hFFFF_0000 : 0);
      4: return ($urandom_range(0, 1) ? 32'h8000_0000 : 32'h7FFF_FFFF);
      default: return 32'($signed($urandom_range(0, 8)) - 4) <<< 16;
    endcase
  endfunction

  function automatic m3i_pkg::m3i_in_t rand_matrix();
    m3i_pkg::m3i_in_t m;
    m = {rand_entry(), rand_entry(), rand_entry(), rand_entry(), rand_entry(),
         rand_entry(), rand_entry(), rand_entry(), rand_entry()};
    // Now and then make a row a copy of another to force singularity.
    if ($urandom_range(0, 9) == 0) {m.m20, m.m21, m.m22} = {m.m00, m.m01, m.m02};
    return m;
  endfunction

  function automatic m3i_pkg::m3i_in_t diag(logic [31:0] a, logic [31:0] b,
                                            logic [31:0] c);
    m3i_pkg::m3i_in_t m;
    m = '0;
    m.m00 = a;
    m.m11 = b;
    m.m22 = c;
    return m;
  endfunction

  task automatic test_directed();
    m3i_pkg::m3i_in_t m;
    send_matrix(diag(32'h0001_0000, 32'h0001_0000, 32'h0001_0000));
    send_matrix(diag(32'h0002_0000, 32'hFFFF_0000, 32'h0000_8000));
    send_matrix('0);
    send_matrix({9{32'h7FFF_FFFF}});
    send_matrix({9{32'h8000_0000}});
    send_matrix(diag(32'h8000_0000, 32'h8000_0000, 32'h8000_0000));
    send_matrix(diag(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF));
    send_matrix(diag(32'h0000_0001, 32'h0000_0001, 32'h0000_0001));
    send_matrix(diag(32'h0000_0100, 32'h0000_0100, 32'h0000_0100));
    // An entry of 2^-15 has inverse 2^15, which clips when positive and is
    // exactly the most negative value when negative.
    send_matrix(diag(32'h0000_0002, 32'h0001_0000, 32'h0001_0000));
    send_matrix(diag(32'hFFFF_FFFE, 32'h0001_0000, 32'h0001_0000));
    m = '0;
    m.m02 = 32'h0001_0000;
    m.m11 = 32'h0001_0000;
    m.m20 = 32'h0001_0000;
    send_matrix(m);
    m = {32'h0001_0000, 32'h0002_0000, 32'h0003_0000, 32'h0000_0000, 32'h0001_0000,
         32'h0004_0000, 32'h0005_0000, 32'h0006_0000, 32'h0000_0000};
    send_matrix(m);
    m = {32'h0001_0000, 32'h0002_0000, 32'h0003_0000, 32'h0004_0000, 32'h0005_0000,
         32'h0006_0000, 32'h0007_0000, 32'h0008_0000, 32'h0009_0000};
    send_matrix(m);
    for (int i = 0; i < 6; i++) send_matrix(rand_matrix());
  endtask

  // Determinant right at the threshold: diag(1 lsb, 1 lsb, k) gives |det| = k.
  task automatic test_threshold_edge();
    write_threshold(32'h0000_0003);
    send_matrix(diag(32'h0000_0001, 32'h0000_0001, 32'h0003_0000));
    send_matrix(diag(32'h0000_0001, 32'h0000_0001, 32'h0003_0001));
    send_matrix(diag(32'h0000_0001, 32'hFFFF_FFFF, 32'h0003_0000));
    write_threshold(32'h0000_0000);
    send_matrix(diag(32'h0000_0001, 32'h0000_0001, 32'h0000_0001));
    send_matrix('0);
    write_threshold(32'hFFFF_FFFF);
    send_matrix(diag(32'h0001_0000, 32'h0001_0000, 32'h0001_0000));
    send_matrix(diag(32'h0100_0000, 32'h0100_0000, 32'h0001_0000));
    for (int i = 0; i < 5; i++) send_matrix(rand_matrix());
  endtask

  task automatic test_random(int count, logic [31:0] thr);
    write_threshold(thr);
    for (int i = 0; i < count; i++) send_matrix(rand_matrix());
  endtask

  // Receiver holds off while the sender keeps offering words.
  task automatic test_back_pressure();
    wait_drained();
    hold_off_cycles = 120;
    for (int i = 0; i < 80; i++) send_matrix(rand_matrix());
  endtask

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    cfg_wr_en = 1'b0;
    cfg_wr_data = '0;
    threshold = m3i_pkg::DET_MIN_RESET;
    error_count = 0;
    idle_cycles = 0;
    hold_off_cycles = 0;
    send_idling = 1'b1;
    recv_idling = 1'b1;
    repeat (12) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    test_directed();
    test_threshold_edge();
    test_random(250, m3i_pkg::DET_MIN_RESET);
    test_back_pressure();
    test_random(250, $urandom());
    send_idling = 1'b0;
    recv_idling = 1'b0;
    test_random(250, m3i_pkg::DET_MIN_RESET);
    wait_drained();
    if (error_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end
endmodule
